/* design/crs_pkg.sv */
`default_nettype none
package crs_pkg;

    localparam int DIVISIONS  = 4;
    localparam int FRAC_BITS  = 16;
    // DIVISIONS is a power of two here, so 2*D^3 is one too
    localparam int DEN_SHIFT  = 3 * $clog2(DIVISIONS) + 1;
    localparam int K_W        = (DIVISIONS > 1) ? $clog2(DIVISIONS) : 1;
    localparam int COORD_W    = 32;
    localparam int W_W        = 12;
    localparam int PROD_W     = COORD_W + W_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = 1;
    localparam int QCNT_W     = 2;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t z;
        coord_t y;
        coord_t x;
    } point_t;

    typedef struct packed {
        point_t far_p;
        point_t near_p;
    } pair_t;

    // One queue entry per input that causes output. pts[3] is the newest point.
    typedef struct packed {
        pair_t [3:0] pts;
        logic        main_en;
        logic        close_en;
        logic        close_clamp;
    } seg_entry_t;

    // Integer Catmull-Rom basis at t = k/D, scaled by 2*D^3.
    function automatic logic signed [W_W-1:0] crs_weight(input logic [K_W-1:0] k,
                                                         input logic [1:0] i);
        int kk;
        int d;
        int w;
        kk = int'(k);
        d  = DIVISIONS;
        unique case (i)
            2'd0:    w = -kk*kk*kk + 2*kk*kk*d - kk*d*d;
            2'd1:    w = 3*kk*kk*kk - 5*kk*kk*d + 2*d*d*d;
            2'd2:    w = -3*kk*kk*kk + 4*kk*kk*d + kk*d*d;
            default: w = kk*kk*kk - kk*kk*d;
        endcase
        return W_W'(w);
    endfunction

endpackage
`default_nettype wire

/* design/catmull_rom_ribbon_subdivider.sv */
`default_nettype none
// Catmull-Rom ribbon subdivider.
// Slave stream: one ribbon control point per transaction (near and far 3D
// points, signed Q16.16); s_tlast marks the final point of a trail.
// Master stream: one vertex per transaction, near then far for each step k of
// a segment; m_tuser is the side (0 near, 1 far), m_tlast flags the last
// vertex caused by an input point. Points that close no segment emit nothing.
// A point that completes a segment is queued; its first vertex then passes the
// multiply, sum and output registers. Throughput: one vertex per cycle unless
// m_tready holds it; a mid-trail point yields 2*DIVISIONS = 8 vertices, the
// final one up to 16; one pipeline (select, multiply, sum, round) sets the rate.
// A two-entry segment queue sits between input handling and the vertex
// pipeline, so points are taken while vertices drain.
// Reset empties the queue and the point window and clears all valid flags.
// When m_tready is low with a vertex waiting, the vertex pipeline holds;
// s_tready drops only when the queue is full.
module catmull_rom_ribbon_subdivider (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // near_x, near_y, near_z, far_x, far_y, far_z
    input  wire logic [191:0] s_tdata,
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // vert_x, vert_y, vert_z, step_index[3:0], 4'b0
    output logic [103:0]      m_tdata,
    // edge_side
    output logic              m_tuser,
    output logic              m_tlast
);
    import crs_pkg::*;

    pair_t          in_pair;
    seg_entry_t     push_entry;
    seg_entry_t     head;
    logic           push;
    logic           q_full;
    logic           q_empty;
    logic           pop;
    point_t         vert;
    logic [K_W-1:0] step;

    assign in_pair.near_p.x = s_tdata[31:0];
    assign in_pair.near_p.y = s_tdata[63:32];
    assign in_pair.near_p.z = s_tdata[95:64];
    assign in_pair.far_p.x  = s_tdata[127:96];
    assign in_pair.far_p.y  = s_tdata[159:128];
    assign in_pair.far_p.z  = s_tdata[191:160];

    crs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_pair    (in_pair),
        .in_last    (s_tlast),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    crs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .empty      (q_empty)
    );

    crs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (q_empty),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_vert  (vert),
        .out_side  (m_tuser),
        .out_step  (step),
        .out_last  (m_tlast)
    );

    assign m_tdata = {4'b0, 4'(step), vert.z, vert.y, vert.x};

endmodule
`default_nettype wire

/* design/crs_front.sv */
`default_nettype none
module crs_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire crs_pkg::pair_t     in_pair,
    input  wire logic               in_last,
    input  wire logic               q_full,
    output logic                    push,
    output crs_pkg::seg_entry_t     push_entry
);
    import crs_pkg::*;

    pair_t      hist_reg [3];   // hist_reg[2] newest
    logic [1:0] seen_reg;
    logic [1:0] seen_next;
    logic       accept;
    logic       main_en;
    logic       close_en;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign main_en  = (seen_reg >= 2'd2);
    assign close_en = in_last && (seen_reg != 2'd0);
    assign push     = accept && (main_en || close_en);

    always_comb
    begin
        push_entry.pts[0]      = (seen_reg == 2'd3) ? hist_reg[0] : hist_reg[1];
        push_entry.pts[1]      = hist_reg[1];
        push_entry.pts[2]      = hist_reg[2];
        push_entry.pts[3]      = in_pair;
        push_entry.main_en     = main_en;
        push_entry.close_en    = close_en;
        push_entry.close_clamp = (seen_reg == 2'd1);
    end

    always_comb
    begin
        if (in_last)
            seen_next = 2'd0;
        else if (seen_reg == 2'd3)
            seen_next = 2'd3;
        else
            seen_next = seen_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= 2'd0;
        else if (accept)
            seen_reg <= seen_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hist_reg[0] <= hist_reg[1];
            hist_reg[1] <= hist_reg[2];
            hist_reg[2] <= in_pair;
        end
    end

endmodule
`default_nettype wire

/* design/crs_queue.sv */
`default_nettype none
module crs_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire crs_pkg::seg_entry_t push_entry,
    output logic                     full,
    input  wire logic                pop,
    output crs_pkg::seg_entry_t      head,
    output logic                     empty
);
    import crs_pkg::*;

    seg_entry_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule
`default_nettype wire

/* design/crs_back.sv */
`default_nettype none
module crs_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire crs_pkg::seg_entry_t head,
    input  wire logic                empty,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output crs_pkg::point_t          out_vert,
    output logic                     out_side,
    output logic [crs_pkg::K_W-1:0]  out_step,
    output logic                     out_last
);
    import crs_pkg::*;

    // issue sequencer
    logic           close_ph_reg;
    logic           close_ph_next;
    logic [K_W-1:0] k_reg;
    logic [K_W-1:0] k_next;
    logic           side_reg;
    logic           side_next;

    // multiply stage
    logic                     m_v_reg;
    logic signed [PROD_W-1:0] prod_reg [3][4];
    logic                     m_side_reg;
    logic [K_W-1:0]           m_k_reg;
    logic                     m_last_reg;

    // sum stage
    logic                    s_v_reg;
    logic signed [SUM_W-1:0] sum_reg [3];
    logic                    s_side_reg;
    logic [K_W-1:0]          s_k_reg;
    logic                    s_last_reg;

    // output register
    logic           out_valid_reg;
    point_t         vert_reg;
    logic           side_out_reg;
    logic [K_W-1:0] step_reg;
    logic           last_reg;

    logic        adv;
    logic        issue;
    logic        seg_close;
    logic        seg_end;
    logic        entry_end;
    pair_t       cp [4];
    point_t      sel [4];
    coord_t      cv [3][4];
    logic signed [W_W-1:0] w [4];
    coord_t      rnd [3];

    function automatic coord_t round_sat(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] r;
        r = (s + SUM_W'(1 << (DEN_SHIFT - 1))) >>> DEN_SHIFT;
        if (r > SUM_W'(2147483647))
            return coord_t'(32'h7FFF_FFFF);
        else if (r < -SUM_W'(64'sd2147483648))
            return coord_t'(32'h8000_0000);
        else
            return r[COORD_W-1:0];
    endfunction

    assign adv       = !out_valid_reg || out_ready;
    assign issue     = adv && !empty;
    assign seg_close = close_ph_reg || !head.main_en;
    assign seg_end   = (k_reg == K_W'(DIVISIONS - 1)) && side_reg;
    assign entry_end = seg_end && (seg_close || !head.close_en);
    assign pop       = issue && entry_end;

    // control points of the current segment; the closing one repeats the last point
    always_comb
    begin
        if (seg_close)
        begin
            cp[0] = head.close_clamp ? head.pts[2] : head.pts[1];
            cp[1] = head.pts[2];
            cp[2] = head.pts[3];
        end
        else
        begin
            cp[0] = head.pts[0];
            cp[1] = head.pts[1];
            cp[2] = head.pts[2];
        end
        cp[3] = head.pts[3];
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            sel[i]   = side_reg ? cp[i].far_p : cp[i].near_p;
            cv[0][i] = sel[i].x;
            cv[1][i] = sel[i].y;
            cv[2][i] = sel[i].z;
            w[i]     = crs_weight(k_reg, 2'(i));
        end
    end

    always_comb
    begin
        close_ph_next = close_ph_reg;
        k_next        = k_reg;
        side_next     = side_reg;
        if (issue)
        begin
            if (seg_end)
            begin
                k_next        = '0;
                side_next     = 1'b0;
                close_ph_next = !entry_end;
            end
            else if (side_reg)
            begin
                side_next = 1'b0;
                k_next    = k_reg + 1'b1;
            end
            else
                side_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            close_ph_reg  <= 1'b0;
            k_reg         <= '0;
            side_reg      <= 1'b0;
            m_v_reg       <= 1'b0;
            s_v_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            close_ph_reg <= close_ph_next;
            k_reg        <= k_next;
            side_reg     <= side_next;
            if (adv)
            begin
                m_v_reg       <= issue;
                s_v_reg       <= m_v_reg;
                out_valid_reg <= s_v_reg;
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
            rnd[c] = round_sat(sum_reg[c]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int i = 0; i < 4; i++)
                    prod_reg[c][i] <= PROD_W'(cv[c][i]) * PROD_W'(w[i]);
                sum_reg[c] <= SUM_W'(prod_reg[c][0]) + SUM_W'(prod_reg[c][1])
                            + SUM_W'(prod_reg[c][2]) + SUM_W'(prod_reg[c][3]);
            end
            m_side_reg   <= side_reg;
            m_k_reg      <= k_reg;
            m_last_reg   <= entry_end;
            s_side_reg   <= m_side_reg;
            s_k_reg      <= m_k_reg;
            s_last_reg   <= m_last_reg;
            vert_reg.x   <= rnd[0];
            vert_reg.y   <= rnd[1];
            vert_reg.z   <= rnd[2];
            side_out_reg <= s_side_reg;
            step_reg     <= s_k_reg;
            last_reg     <= s_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_vert  = vert_reg;
    assign out_side  = side_out_reg;
    assign out_step  = step_reg;
    assign out_last  = last_reg;

endmodule
`default_nettype wire

/* dv/testbench.sv */
class vertex_scoreboard;
    typedef struct {
        crs_pkg::coord_t x;
        crs_pkg::coord_t y;
        crs_pkg::coord_t z;
        bit              side;
        bit [3:0]        step;
        bit              last;
    } vertex_t;

    localparam int     RUN_CAP   = 16;
    localparam longint COORD_MAX = 64'sd2147483647;
    localparam longint COORD_MIN = -64'sd2147483648;

    vertex_t expected_vertices[$];
    vertex_t run_q[$];
    // rows 0..stored-1 hold the window, oldest first; row stored takes the new point
    longint  near_pts[4][3];
    longint  far_pts[4][3];
    int      stored;
    int      errors;

    function new();
        stored = 0;
        errors = 0;
    endfunction

    // Catmull-Rom at t = k/D, exact rational, rounded half up, then saturated
    function crs_pkg::coord_t spline_point(longint p0, longint p1, longint p2, longint p3,
                                           longint k);
        longint d;
        longint v0;
        longint v1;
        longint a;
        longint b;
        longint num;
        longint den;
        longint q;
        d   = crs_pkg::DIVISIONS;
        v0  = p2 - p0;
        v1  = p3 - p1;
        a   = 4 * p1 - 4 * p2 + v0 + v1;
        b   = -6 * p1 + 6 * p2 - 2 * v0 - v1;
        den = 2 * d * d * d;
        num = a * k * k * k + b * k * k * d + v0 * k * d * d + 2 * p1 * d * d * d + den / 2;
        q   = num / den;
        if (num % den != 0 && num < 0)
            q--;
        if (q > COORD_MAX)
            q = COORD_MAX;
        if (q < COORD_MIN)
            q = COORD_MIN;
        return crs_pkg::coord_t'(q);
    endfunction

    function void add_segment(int i0, int i1, int i2, int i3);
        vertex_t         v;
        crs_pkg::coord_t c[3];
        for (int k = 0; k < crs_pkg::DIVISIONS; k++)
        begin
            for (int side = 0; side < 2; side++)
            begin
                if (run_q.size() >= RUN_CAP)
                    return;
                for (int ax = 0; ax < 3; ax++)
                begin
                    if (side != 0)
                        c[ax] = spline_point(far_pts[i0][ax], far_pts[i1][ax],
                                             far_pts[i2][ax], far_pts[i3][ax], k);
                    else
                        c[ax] = spline_point(near_pts[i0][ax], near_pts[i1][ax],
                                             near_pts[i2][ax], near_pts[i3][ax], k);
                end
                v.x    = c[0];
                v.y    = c[1];
                v.z    = c[2];
                v.side = side[0];
                v.step = k[3:0];
                v.last = 1'b0;
                run_q.insert(run_q.size(), v);
            end
        end
    endfunction

    function void note_point(logic [191:0] data, bit trail_end);
        int cnt;
        run_q.delete();
        for (int ax = 0; ax < 3; ax++)
        begin
            near_pts[stored][ax] = $signed(data[32*ax +: 32]);
            far_pts[stored][ax]  = $signed(data[96 + 32*ax +: 32]);
        end
        cnt = stored + 1;
        if (cnt >= 3)
            add_segment((cnt >= 4) ? cnt - 4 : cnt - 3, cnt - 3, cnt - 2, cnt - 1);
        // closing segment clamps p3 to p2
        if (trail_end && cnt >= 2)
            add_segment((cnt >= 3) ? cnt - 3 : cnt - 2, cnt - 2, cnt - 1, cnt - 1);
        if (run_q.size() > 0)
            run_q[run_q.size() - 1].last = 1'b1;
        foreach (run_q[i])
            expected_vertices.insert(expected_vertices.size(), run_q[i]);
        if (trail_end)
            stored = 0;
        else if (cnt > 3)
        begin
            for (int j = 0; j < 3; j++)
            begin
                near_pts[j] = near_pts[j + 1];
                far_pts[j]  = far_pts[j + 1];
            end
            stored = 3;
        end
        else
            stored = cnt;
    endfunction

    function void compare_field(string name, longint want, longint got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    function void check_vertex(logic [103:0] data, bit side, bit last);
        vertex_t want;
        if (expected_vertices.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected vertex: expected none, actual x=%0d y=%0d z=%0d",
                     $time, $signed(data[31:0]), $signed(data[63:32]), $signed(data[95:64]));
            return;
        end
        want = expected_vertices.pop_front();
        compare_field("vert_x", want.x, $signed(data[31:0]));
        compare_field("vert_y", want.y, $signed(data[63:32]));
        compare_field("vert_z", want.z, $signed(data[95:64]));
        compare_field("step_index", want.step, data[99:96]);
        compare_field("edge_side", want.side, side);
        compare_field("run_end", want.last, last);
    endfunction

    function int pending();
        return expected_vertices.size();
    endfunction
endclass

module testbench;
    import crs_pkg::*;

    localparam int          IDLE_LIMIT    = 2000;
    localparam int          RANDOM_POINTS = 430;
    localparam int          CALM_POINTS   = 60;
    localparam logic [31:0] Q_MAX         = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN         = 32'h8000_0000;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;

    bit           tx_idle_en = 1'b1;
    bit           rx_idle_en = 1'b1;
    int           idle_cycles = 0;
    int           sent = 0;

    vertex_scoreboard sb;

    catmull_rom_ribbon_subdivider dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
        sb = new();

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_point(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                sb.check_vertex(m_tdata, m_tuser, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // result side backpressure
    initial
    begin
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (rx_idle_en && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    end

    function automatic logic [31:0] pick_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        else if (sel < 7)
            return $urandom;
        else
        begin
            case ($urandom_range(0, 4))
                0:       return Q_MAX;
                1:       return Q_MIN;
                2:       return 32'h0000_0000;
                3:       return 32'hFFFF_FFFF;
                default: return 32'h0001_0000;
            endcase
        end
    endfunction

    function automatic logic [191:0] random_point();
        logic [191:0] p;
        for (int i = 0; i < 6; i++)
            p[32*i +: 32] = pick_coord();
        return p;
    endfunction

    function automatic logic [191:0] uniform_point(logic [31:0] near_c, logic [31:0] far_c);
        return {far_c, far_c, far_c, near_c, near_c, near_c};
    endfunction

    task automatic send_point(input logic [191:0] data, input bit trail_end);
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= trail_end;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_trail();
        int len;
        int sel;
        sel = $urandom_range(0, 9);
        len = (sel == 0) ? 1 : (sel == 1) ? 2 : $urandom_range(3, 12);
        for (int i = 0; i < len; i++)
            send_point(random_point(), i == len - 1);
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lone point: no segment
        send_point(uniform_point(32'h0, 32'h0), 1'b1);
        // two-point trail: only the clamped closing segment
        send_point(uniform_point(Q_MAX, Q_MIN), 1'b0);
        send_point(uniform_point(Q_MIN, Q_MAX), 1'b1);
        // three points: clamped first segment plus closing one
        send_point(uniform_point(Q_MAX, Q_MIN), 1'b0);
        send_point(uniform_point(Q_MIN, Q_MAX), 1'b0);
        send_point(uniform_point(Q_MAX, Q_MIN), 1'b1);
        // alternating extremes overshoot and saturate
        for (int i = 0; i < 5; i++)
            send_point(uniform_point(i[0] ? Q_MIN : Q_MAX, i[0] ? Q_MAX : Q_MIN), i == 4);
        send_point(uniform_point(Q_MIN, Q_MAX), 1'b1);
        // small ramp
        for (int i = 0; i < 4; i++)
            send_point(uniform_point(i << 16, -(i << 16)), i == 3);

        // hold off until every vertex so far has drained
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);

        sent = 0;
        while (sent < RANDOM_POINTS)
        begin
            if (sent >= RANDOM_POINTS - CALM_POINTS)
            begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            send_trail();
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

/* files.f */
design/crs_pkg.sv
design/crs_front.sv
design/crs_queue.sv
design/crs_back.sv
design/catmull_rom_ribbon_subdivider.sv
dv/testbench.sv
